@@ src/dts_pkg.sv @@
// Shared types, codes and constants for the deadline timer scheduler.
package dts_pkg;

  localparam int DTS_SLOTS       = 32;
  localparam int DTS_MAX_RESULTS = 32;
  localparam int DTS_TIME_W      = 47;
  localparam int DTS_RETRY_W     = 16;
  localparam int DTS_ID_W        = 5;

  localparam logic [DTS_TIME_W-1:0]  DTS_NEVER       = {DTS_TIME_W{1'b1}};
  localparam logic [DTS_RETRY_W-1:0] DTS_RETRY_RESET = 16'd2000;

  localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
  localparam logic [1:0] FUNC_CANCEL   = 2'd1;
  localparam logic [1:0] FUNC_PROCESS  = 2'd2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [DTS_TIME_W-1:0] key_dl;
  } dts_cmd_t;

endpackage

@@ src/dts_cell.sv @@
// One cell of the sorted deadline row: holds one entry and trades with its neighbors.
module dts_cell
  import dts_pkg::*;
#(
  parameter int SW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dts_cmd_t              cmd,
  input  logic [SW-1:0]         key_slot,
  input  logic                  left_v,
  input  logic [SW-1:0]         left_slot,
  input  logic [DTS_TIME_W-1:0] left_dl,
  input  logic                  left_gt,
  input  logic                  right_v,
  input  logic [SW-1:0]         right_slot,
  input  logic [DTS_TIME_W-1:0] right_dl,
  output logic                  v,
  output logic [SW-1:0]         slot,
  output logic [DTS_TIME_W-1:0] dl,
  output logic                  gt,
  output logic                  match
);

  logic                  v_r, v_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [DTS_TIME_W-1:0] dl_r, dl_nxt;
  logic                  key_lt, key_eq, ge;

  assign key_lt = (cmd.key_dl < dl_r) || ((cmd.key_dl == dl_r) && (key_slot < slot_r));
  assign key_eq = (cmd.key_dl == dl_r) && (key_slot == slot_r);
  assign gt     = !v_r || key_lt;
  assign ge     = v_r && (key_lt || key_eq);
  assign match  = v_r && (slot_r == key_slot);

  always_comb begin
    v_nxt    = v_r;
    slot_nxt = slot_r;
    dl_nxt   = dl_r;
    case (cmd.op)
      OP_POP: begin
        v_nxt    = right_v;
        slot_nxt = right_slot;
        dl_nxt   = right_dl;
      end
      OP_REMOVE: begin
        if (ge) begin
          v_nxt    = right_v;
          slot_nxt = right_slot;
          dl_nxt   = right_dl;
        end
      end
      OP_INSERT: begin
        if (left_gt) begin
          v_nxt    = left_v;
          slot_nxt = left_slot;
          dl_nxt   = left_dl;
        end else if (gt) begin
          v_nxt    = 1'b1;
          slot_nxt = key_slot;
          dl_nxt   = cmd.key_dl;
        end
      end
      default: begin
        v_nxt = v_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    dl_r   <= dl_nxt;
  end

  assign v    = v_r;
  assign slot = slot_r;
  assign dl   = dl_r;

endmodule

@@ src/dts_queue.sv @@
// Row of cells that keeps pending deadlines sorted, earliest at the front.
module dts_queue
  import dts_pkg::*;
#(
  parameter int SLOTS = DTS_SLOTS,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dts_cmd_t              cmd,
  input  logic [SW-1:0]         key_slot,
  output logic                  head_v,
  output logic [SW-1:0]         head_slot,
  output logic [DTS_TIME_W-1:0] head_dl,
  output logic                  next_v,
  output logic [DTS_TIME_W-1:0] next_dl,
  output logic                  found,
  output logic [DTS_TIME_W-1:0] found_dl
);

  logic                  v_w     [SLOTS];
  logic [SW-1:0]         slot_w  [SLOTS];
  logic [DTS_TIME_W-1:0] dl_w    [SLOTS];
  logic                  gt_w    [SLOTS];
  logic                  match_w [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                  l_v, l_gt, r_v;
    logic [SW-1:0]         l_slot, r_slot;
    logic [DTS_TIME_W-1:0] l_dl, r_dl;

    if (i == 0) begin : g_first
      assign l_v    = 1'b0;
      assign l_slot = '0;
      assign l_dl   = '0;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_v    = v_w[i-1];
      assign l_slot = slot_w[i-1];
      assign l_dl   = dl_w[i-1];
      assign l_gt   = gt_w[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign r_v    = 1'b0;
      assign r_slot = '0;
      assign r_dl   = '0;
    end else begin : g_inner
      assign r_v    = v_w[i+1];
      assign r_slot = slot_w[i+1];
      assign r_dl   = dl_w[i+1];
    end

    dts_cell #(.SW(SW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key_slot   (key_slot),
      .left_v     (l_v),
      .left_slot  (l_slot),
      .left_dl    (l_dl),
      .left_gt    (l_gt),
      .right_v    (r_v),
      .right_slot (r_slot),
      .right_dl   (r_dl),
      .v          (v_w[i]),
      .slot       (slot_w[i]),
      .dl         (dl_w[i]),
      .gt         (gt_w[i]),
      .match      (match_w[i])
    );
  end

  always_comb begin
    found    = 1'b0;
    found_dl = '0;
    for (int i = 0; i < SLOTS; i++) begin
      found    = found | match_w[i];
      found_dl = found_dl | (match_w[i] ? dl_w[i] : '0);
    end
  end

  assign head_v    = v_w[0];
  assign head_slot = slot_w[0];
  assign head_dl   = dl_w[0];
  assign next_v    = v_w[1];
  assign next_dl   = dl_w[1];

endmodule

@@ src/deadline_timer_scheduler_core.sv @@
// Deadline timer scheduler top level: control sequencer, output register and cell row.
//
// Channel | Direction | Contents
// in_     | slave     | tuser: func; tdata: slot_id, target_time, now
// out_    | master    | tdata: due_slot .. head_time; tlast: last
// cfg_    | write     | retry_delay
//
// A schedule or cancel locates the slot in the cell row, closes its gap if the slot was found,
// inserts the new entry if one is to be scheduled, and then reports.
// An unknown func goes straight to the report state after its transfer.
// A process item gives one due slot per cycle while the output is not stalled, since the row
// shifts every cell at once. Reset empties the row. A stalled output holds the sequencer, but
// the next item is taken as soon as the sequencer is idle, while a result still waits.
module deadline_timer_scheduler_core
  import dts_pkg::*;
#(
  parameter int SLOTS = DTS_SLOTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // slot_id[4:0], target_time[52:5], now[99:53], zeros
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // due_slot[4:0], is_due, wake, bad_target, head_valid,
                                   // head_time[55:9]
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(DTS_MAX_RESULTS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIND   = 3'd1;
  localparam logic [2:0] ST_REMOVE = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;
  localparam logic [2:0] ST_PROC   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             func_r, func_nxt;
  logic [DTS_ID_W-1:0]    slot_r, slot_nxt;
  logic [DTS_TIME_W-1:0]  t_r, t_nxt;
  logic [DTS_TIME_W-1:0]  now_r, now_nxt;
  logic [DTS_TIME_W-1:0]  key_dl_r, key_dl_nxt;
  logic                   bad_r, bad_nxt;
  logic                   wake_r, wake_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DTS_RETRY_W-1:0] retry_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [55:0]            out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [1:0]            in_func;
  logic [DTS_ID_W-1:0]   in_slot;
  logic [47:0]           in_target;
  logic [DTS_TIME_W-1:0] in_now;
  logic [47:0]           retry_sum;
  logic [DTS_TIME_W-1:0] sub_time;
  logic                  in_bad;
  logic                  in_range;
  logic                  need_insert;
  logic                  out_free;
  logic                  head_due, next_due, last_due;
  logic [DTS_TIME_W-1:0] prev_head;

  dts_cmd_t              cmd;
  logic [SW-1:0]         key_slot;
  logic                  head_v, next_v, found;
  logic [SW-1:0]         head_slot;
  logic [DTS_TIME_W-1:0] head_dl, next_dl, found_dl;

  assign in_func   = in_tuser;
  assign in_slot   = in_tdata[4:0];
  assign in_target = in_tdata[52:5];
  assign in_now    = in_tdata[99:53];

  assign in_bad    = in_target[47] || (in_target == '0);
  assign retry_sum = {1'b0, in_now} + 48'(retry_r);
  assign sub_time  = (retry_sum >= {1'b0, DTS_NEVER}) ? (DTS_NEVER - 1'b1) : retry_sum[46:0];

  assign in_range    = 32'(slot_r) < SLOTS;
  assign need_insert = (func_r == FUNC_SCHEDULE) && in_range && (t_r != DTS_NEVER);
  assign key_slot    = SW'(slot_r);
  assign prev_head   = head_v ? head_dl : DTS_NEVER;
  assign out_free    = !out_valid_r || out_tready;
  assign head_due    = head_v && (head_dl < now_r);
  assign next_due    = next_v && (next_dl < now_r);
  assign last_due    = !next_due || (cnt_r == CW'(DTS_MAX_RESULTS - 1));
  assign in_tready   = rst_n && (state_r == ST_IDLE);

  dts_queue #(.SLOTS(SLOTS), .SW(SW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_slot  (key_slot),
    .head_v    (head_v),
    .head_slot (head_slot),
    .head_dl   (head_dl),
    .next_v    (next_v),
    .next_dl   (next_dl),
    .found     (found),
    .found_dl  (found_dl)
  );

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    slot_nxt      = slot_r;
    t_nxt         = t_r;
    now_nxt       = now_r;
    key_dl_nxt    = key_dl_r;
    bad_nxt       = bad_r;
    wake_nxt      = wake_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cmd.op        = OP_HOLD;
    cmd.key_dl    = (state_r == ST_REMOVE) ? key_dl_r : t_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_func;
          slot_nxt = in_slot;
          now_nxt  = in_now;
          t_nxt    = in_bad ? sub_time : in_target[46:0];
          bad_nxt  = (in_func == FUNC_SCHEDULE) && in_bad;
          wake_nxt = 1'b0;
          cnt_nxt  = '0;
          case (in_func)
            FUNC_SCHEDULE: state_nxt = ST_FIND;
            FUNC_CANCEL:   state_nxt = ST_FIND;
            FUNC_PROCESS:  state_nxt = ST_PROC;
            default:       state_nxt = ST_REPORT;
          endcase
        end
      end
      ST_FIND: begin
        if (!in_range) begin
          state_nxt = ST_REPORT;
        end else begin
          wake_nxt   = need_insert && (t_r < prev_head);
          key_dl_nxt = found_dl;
          if (found) begin
            state_nxt = ST_REMOVE;
          end else if (need_insert) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_REMOVE: begin
        cmd.op    = OP_REMOVE;
        state_nxt = need_insert ? ST_INSERT : ST_REPORT;
      end
      ST_INSERT: begin
        cmd.op    = OP_INSERT;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(head_v ? head_dl : DTS_NEVER), head_v, bad_r, wake_r, 1'b0,
                           {DTS_ID_W{1'b0}}};
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PROC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (head_due && (cnt_r < CW'(DTS_MAX_RESULTS))) begin
            cmd.op       = OP_POP;
            cnt_nxt      = cnt_r + 1'b1;
            out_data_nxt = {(next_v ? next_dl : DTS_NEVER), next_v, 1'b0, 1'b0, 1'b1,
                            DTS_ID_W'(head_slot)};
            out_last_nxt = last_due;
            if (last_due) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_data_nxt = {(head_v ? head_dl : DTS_NEVER), head_v, 1'b0, 1'b0, 1'b0,
                            {DTS_ID_W{1'b0}}};
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      retry_r     <= DTS_RETRY_RESET;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        retry_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    slot_r     <= slot_nxt;
    t_r        <= t_nxt;
    now_r      <= now_nxt;
    key_dl_r   <= key_dl_nxt;
    bad_r      <= bad_nxt;
    wake_r     <= wake_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
